/* rtl/core/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] LF_CHAR    = 8'h0A;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_ATTR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_ATTR  = 1'b1;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_SET   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] ch;
      logic [7:0] attr;
      logic [4:0] row;
      logic [6:0] col;
   } req_item_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_pos;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
      logic        scrolled;
   } rsp_item_type;

   // where a sweep of the cell store starts
   typedef enum logic [1:0] {
      IDX_ZERO     = 2'd0,
      IDX_ROW1     = 2'd1,
      IDX_LAST_ROW = 2'd2
   } idx_sel_type;

   // attribute written by a fill sweep
   typedef enum logic [1:0] {
      FILL_RESET   = 2'd0,
      FILL_DEFAULT = 2'd1,
      FILL_SCROLL  = 2'd2
   } fill_sel_type;

   typedef struct packed {
      logic         load_item;
      logic         calc_addr;
      logic         exec;
      logic         idx_load;
      idx_sel_type  idx_sel;
      logic         copy_step;
      logic         fill_step;
      fill_sel_type fill_sel;
      logic         load_rsp;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    need_scroll;
      logic    idx_last;
      logic    rsp_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/core/tcw_ctrl.sv */
`default_nettype none

module tcw_ctrl
   import tcw_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  status_type status,
   output ctl_type    ctl
);

   typedef enum logic [8:0] {
      ST_INIT  = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_ADDR  = 9'b000000100,
      ST_EXEC  = 9'b000001000,
      ST_COPY  = 9'b000010000,
      ST_DRAIN = 9'b000100000,
      ST_FILL  = 9'b001000000,
      ST_CLEAR = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      ctl.load_item = 1'b0;
      ctl.calc_addr = 1'b0;
      ctl.exec      = 1'b0;
      ctl.idx_load  = 1'b0;
      ctl.idx_sel   = IDX_ZERO;
      ctl.copy_step = 1'b0;
      ctl.fill_step = 1'b0;
      ctl.fill_sel  = FILL_RESET;
      ctl.load_rsp  = 1'b0;
      case (state_ff)
         ST_INIT: begin
            ctl.fill_step = 1'b1;
            ctl.fill_sel  = FILL_RESET;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.load_item = 1'b1;
               state_in      = ST_ADDR;
            end
         end
         ST_ADDR: begin
            ctl.calc_addr = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            case (status.cmd)
               CMD_PUT: begin
                  if (status.need_scroll) begin
                     ctl.idx_load = 1'b1;
                     ctl.idx_sel  = IDX_ROW1;
                     state_in     = ST_COPY;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               CMD_CLEAR: begin
                  ctl.idx_load = 1'b1;
                  ctl.idx_sel  = IDX_ZERO;
                  state_in     = ST_CLEAR;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_COPY: begin
            ctl.copy_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last copy write lands here
            ctl.idx_load = 1'b1;
            ctl.idx_sel  = IDX_LAST_ROW;
            state_in     = ST_FILL;
         end
         ST_FILL: begin
            ctl.fill_step = 1'b1;
            ctl.fill_sel  = FILL_SCROLL;
            if (status.idx_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            ctl.fill_step = 1'b1;
            ctl.fill_sel  = FILL_DEFAULT;
            if (status.idx_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tcw_dpath.sv */
`default_nettype none

module tcw_dpath
   import tcw_pkg::*;
#(
   parameter int SCREEN_ROWS = 25,
   parameter int SCREEN_COLS = 80
) (
   input  wire                        clock,
   input  wire                        reset,
   input  req_item_type               req_data,
   output rsp_item_type               rsp_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   input  wire                        csr_write_en,
   input  wire  [CSR_INDEX_W-1:0]     csr_index,
   input  wire  [CSR_DATA_W-1:0]      csr_wdata,
   input  ctl_type                    ctl,
   output status_type                 status
);

   localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
   localparam int RW    = $clog2(SCREEN_ROWS);
   localparam int CW    = $clog2(SCREEN_COLS);
   localparam int AW    = $clog2(CELLS);

   localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

   logic [7:0]    default_attr_ff;
   logic [7:0]    scroll_attr_ff;

   cmd_type       cmd_ff;
   logic [7:0]    ch_ff;
   logic [7:0]    attr_ff;
   logic [RW-1:0] r_ff;
   logic [CW-1:0] c_ff;

   logic [RW-1:0] cur_row_ff;
   logic [CW-1:0] cur_col_ff;
   logic          scroll_ff;

   logic [AW-1:0] addr_ff;
   logic [AW-1:0] idx_ff;
   logic          copy_pend_ff;
   logic [AW-1:0] copy_dst_ff;
   logic [15:0]   rd_data_ff;
   logic [15:0]   cell_store_ff [CELLS];

   rsp_item_type  rsp_ff;
   logic          rsp_valid_ff;

   logic          is_cr;
   logic          is_lf;
   logic          put_wr;
   logic          row_adv;
   logic          need_scroll;
   logic [RW-1:0] sel_row;
   logic [CW-1:0] sel_col;
   logic [AW-1:0] rd_addr;
   logic [7:0]    fill_attr;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= RESET_ATTR;
         scroll_attr_ff  <= RESET_ATTR;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEFAULT_ATTR: default_attr_ff <= csr_wdata;
            CSR_SCROLL_ATTR:  scroll_attr_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // item capture with clamping
   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff  <= req_data.cmd;
         ch_ff   <= req_data.ch;
         attr_ff <= req_data.attr;
         r_ff    <= (int'(req_data.row) > SCREEN_ROWS - 1) ? LAST_ROW : RW'(req_data.row);
         c_ff    <= (int'(req_data.col) > SCREEN_COLS - 1) ? LAST_COL : CW'(req_data.col);
      end
   end

   assign is_cr   = (ch_ff == CR_CHAR);
   assign is_lf   = (ch_ff == LF_CHAR);
   assign put_wr  = ctl.exec && (cmd_ff == CMD_PUT) && !is_cr && !is_lf;
   // a put moves to the next row on line feed or after the last column
   assign row_adv = is_lf || (!is_cr && (cur_col_ff == LAST_COL));
   assign need_scroll = (cmd_ff == CMD_PUT) && row_adv && (cur_row_ff == LAST_ROW);

   assign sel_row = (cmd_ff == CMD_READ) ? r_ff : cur_row_ff;
   assign sel_col = (cmd_ff == CMD_READ) ? c_ff : cur_col_ff;

   always_ff @(posedge clock) begin
      if (ctl.calc_addr) begin
         addr_ff <= AW'(int'(sel_row) * SCREEN_COLS + int'(sel_col));
      end
   end

   // cursor update
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         scroll_ff  <= 1'b0;
      end else if (ctl.exec) begin
         scroll_ff <= need_scroll;
         case (cmd_ff)
            CMD_PUT: begin
               if (is_cr || row_adv) begin
                  cur_col_ff <= '0;
               end else begin
                  cur_col_ff <= cur_col_ff + CW'(1);
               end
               if (row_adv && (cur_row_ff != LAST_ROW)) begin
                  cur_row_ff <= cur_row_ff + RW'(1);
               end
            end
            CMD_SET: begin
               cur_row_ff <= r_ff;
               cur_col_ff <= c_ff;
            end
            CMD_CLEAR: begin
               cur_row_ff <= '0;
               cur_col_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // sweep counter for reset fill, clear and scroll
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctl.idx_load) begin
         case (ctl.idx_sel)
            IDX_ROW1:     idx_ff <= AW'(SCREEN_COLS);
            IDX_LAST_ROW: idx_ff <= AW'((SCREEN_ROWS - 1) * SCREEN_COLS);
            default:      idx_ff <= '0;
         endcase
      end else if (ctl.copy_step || ctl.fill_step) begin
         idx_ff <= idx_ff + AW'(1);
      end
   end

   always_comb begin
      case (ctl.fill_sel)
         FILL_DEFAULT: fill_attr = default_attr_ff;
         FILL_SCROLL:  fill_attr = scroll_attr_ff;
         default:      fill_attr = RESET_ATTR;
      endcase
   end

   // copy reads one row ahead, writes the word read in the previous cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         copy_pend_ff <= 1'b0;
      end else begin
         copy_pend_ff <= ctl.copy_step;
      end
   end

   always_ff @(posedge clock) begin
      copy_dst_ff <= idx_ff - AW'(SCREEN_COLS);
   end

   assign rd_addr = ctl.copy_step ? idx_ff : addr_ff;

   // cell store: character in the low byte, attribute in the high byte
   always_ff @(posedge clock) begin
      if (copy_pend_ff) begin
         cell_store_ff[copy_dst_ff] <= rd_data_ff;
      end else if (ctl.fill_step) begin
         cell_store_ff[idx_ff] <= {fill_attr, SPACE_CHAR};
      end else if (put_wr) begin
         cell_store_ff[addr_ff] <= {attr_ff, ch_ff};
      end
      rd_data_ff <= cell_store_ff[rd_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_ff.cursor_row <= 5'(cur_row_ff);
         rsp_ff.cursor_col <= 7'(cur_col_ff);
         rsp_ff.cursor_pos <= 11'(int'(cur_row_ff) * SCREEN_COLS + int'(cur_col_ff));
         rsp_ff.read_char  <= (cmd_ff == CMD_READ) ? rd_data_ff[7:0] : 8'h00;
         rsp_ff.read_attr  <= (cmd_ff == CMD_READ) ? rd_data_ff[15:8] : 8'h00;
         rsp_ff.scrolled   <= scroll_ff && (cmd_ff == CMD_PUT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.cmd         = cmd_ff;
   assign status.need_scroll = need_scroll;
   assign status.idx_last    = (idx_ff == AW'(CELLS - 1));
   assign status.rsp_free    = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

/* rtl/core/text_console_writer.sv */
// Text-mode console: a SCREEN_ROWS x SCREEN_COLS cell store with a cursor.
// req channel (req_valid/req_stall/req_data) takes one command item:
//   put character, set cursor, clear screen or read cell.
// rsp channel (rsp_valid/rsp_stall/rsp_data) returns exactly one item per
//   command, in order, with the cursor, its linear position, the cell read
//   and a scroll flag.
// csr port writes default_attr (index 0) and scroll_attr (index 1); write
//   only while no command is in flight.
// Steps: put, set cursor and read pass through accept, address multiply,
//   store access and result load before the next accept; result load waits
//   while the result register is held, and the result is registered there.
// A clear and a put that scrolls sweep the store before the result load: the
//   single write port of the cell store moves or fills one cell a cycle.
// After reset the store is filled with spaces in attribute 7, one cell a
//   cycle; req_stall stays high during that pass, csr writes are taken.
// One result register sits at the output; a stalled receiver holds it, and
//   the next item is still accepted and worked on until its result is ready.
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int SCREEN_ROWS = 25,
   parameter int SCREEN_COLS = 80
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  req_item_type           req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output rsp_item_type           rsp_data,
   input  wire                    csr_write_en,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_wdata
);

   ctl_type    ctl;
   status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctl       (ctl)
   );

   tcw_dpath #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_data     (rsp_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .ctl          (ctl),
      .status       (status)
   );

endmodule

`default_nettype wire

/* test/console_checker.sv */
module console_checker
   import tcw_pkg::*;
#(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_stall,
   input  req_item_type           req_data,
   input  wire                    rsp_valid,
   input  wire                    rsp_stall,
   input  rsp_item_type           rsp_data,
   input  wire                    csr_write_en,
   input  wire  [CSR_INDEX_W-1:0] csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_wdata,
   output int                     pending,
   output int                     mismatches
);

   localparam int CELLS = ROWS * COLS;

   // attribute in the high byte, character in the low byte
   logic [15:0]  screen [CELLS];
   int           cur_row;
   int           cur_col;
   logic [7:0]   clear_attr;
   logic [7:0]   blank_attr;
   rsp_item_type predicted_reports [$];

   function automatic void fill_screen(input logic [7:0] attr);
      for (int i = 0; i < CELLS; i++) screen[i] = {attr, SPACE_CHAR};
   endfunction

   function automatic rsp_item_type console_step(input req_item_type it);
      rsp_item_type rep;
      int           r;
      int           c;
      rep = '0;
      r = (int'(it.row) > ROWS - 1) ? ROWS - 1 : int'(it.row);
      c = (int'(it.col) > COLS - 1) ? COLS - 1 : int'(it.col);
      case (it.cmd)
         CMD_PUT: begin
            if (it.ch == CR_CHAR) begin
               cur_col = 0;
            end else if (it.ch == LF_CHAR) begin
               cur_row++;
               cur_col = 0;
            end else begin
               screen[cur_row * COLS + cur_col] = {it.attr, it.ch};
               cur_col++;
            end
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            // ran off the bottom: move everything up a row, blank the last one
            if (cur_row >= ROWS) begin
               for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
               for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {blank_attr, SPACE_CHAR};
               cur_row = ROWS - 1;
               rep.scrolled = 1'b1;
            end
         end
         CMD_SET: begin
            cur_row = r;
            cur_col = c;
         end
         CMD_CLEAR: begin
            fill_screen(clear_attr);
            cur_row = 0;
            cur_col = 0;
         end
         default: begin
            {rep.read_attr, rep.read_char} = screen[r * COLS + c];
         end
      endcase
      rep.cursor_row = cur_row[4:0];
      rep.cursor_col = cur_col[6:0];
      rep.cursor_pos = 11'(cur_row * COLS + cur_col);
      return rep;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         fill_screen(RESET_ATTR);
         cur_row = 0;
         cur_col = 0;
         clear_attr = RESET_ATTR;
         blank_attr = RESET_ATTR;
         predicted_reports.delete();
         mismatches = 0;
         pending <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEFAULT_ATTR: clear_attr = csr_wdata;
               CSR_SCROLL_ATTR:  blank_attr = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predicted_reports.push_back(console_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t: result item with no command waiting, actual %h", $time, rsp_data);
               mismatches++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("cursor_row", int'(want.cursor_row), int'(rsp_data.cursor_row));
               check_field("cursor_col", int'(want.cursor_col), int'(rsp_data.cursor_col));
               check_field("cursor_pos", int'(want.cursor_pos), int'(rsp_data.cursor_pos));
               check_field("read_char", int'(want.read_char), int'(rsp_data.read_char));
               check_field("read_attr", int'(want.read_attr), int'(rsp_data.read_attr));
               check_field("scrolled", int'(want.scrolled), int'(rsp_data.scrolled));
            end
         end
         pending <= predicted_reports.size();
      end
   end

endmodule

/* test/testbench.sv */
module testbench
   import tcw_pkg::*;
;

   localparam int ROWS        = 25;
   localparam int COLS        = 80;
   // a clear or a scroll walks the whole store, plus the fill pass after reset
   localparam int QUIET_LIMIT = 20000;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_item_type           req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_item_type           rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   int pending;
   int mismatches;
   int items_sent  = 0;
   int burst_left  = 0;
   int quiet_count = 0;
   int stall_left  = 0;
   int flow_left   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   text_console_writer #(
      .SCREEN_ROWS(ROWS),
      .SCREEN_COLS(COLS)
   ) u_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_write_en,
      .csr_index,
      .csr_wdata
   );

   console_checker #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_write_en,
      .csr_index,
      .csr_wdata,
      .pending,
      .mismatches
   );

   // receiver: long free-flowing runs mixed with short choppy stretches
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (flow_left > 0) begin
         flow_left <= flow_left - 1;
         rsp_stall <= 1'b0;
      end else begin
         flow_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
         stall_left <= $urandom_range(0, 7);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_count <= 0;
      end else begin
         quiet_count <= quiet_count + 1;
         if (quiet_count >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   function automatic req_item_type make_req(input cmd_type op, input logic [7:0] ch,
                                             input logic [7:0] attr, input logic [4:0] row,
                                             input logic [6:0] col);
      req_item_type it;
      it.cmd  = op;
      it.ch   = ch;
      it.attr = attr;
      it.row  = row;
      it.col  = col;
      return it;
   endfunction

   function automatic req_item_type random_req(input cmd_type op);
      return make_req(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
   endfunction

   task automatic send(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // one edge first so the count includes an item taken at this very edge
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_attrs(input logic [7:0] clear_attr, input logic [7:0] blank_attr);
      csr_write_en <= 1'b1;
      csr_index <= CSR_DEFAULT_ATTR;
      csr_wdata <= clear_attr;
      @(posedge clock);
      csr_index <= CSR_SCROLL_ATTR;
      csr_wdata <= blank_attr;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // a line of text ending in CR LF, sometimes long enough to wrap
   task automatic send_line();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 20);
      repeat (n) send(random_req(CMD_PUT));
      send(make_req(CMD_PUT, CR_CHAR, 8'($urandom_range(0, 255)), 5'd0, 7'd0));
      send(make_req(CMD_PUT, LF_CHAR, 8'($urandom_range(0, 255)), 5'd0, 7'd0));
   endtask

   initial begin
      req_item_type it;
      int           kind;
      int           target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_attrs(8'hFF, 8'h00);

      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
      send(make_req(CMD_PUT, 8'h41, 8'hFF, 5'd31, 7'd127));
      send(make_req(CMD_PUT, 8'h00, 8'h00, 5'd0, 7'd0));
      send(make_req(CMD_PUT, 8'hFF, 8'h80, 5'd0, 7'd0));
      send(make_req(CMD_PUT, CR_CHAR, 8'h12, 5'd5, 7'd5));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd2));
      send(make_req(CMD_PUT, LF_CHAR, 8'h34, 5'd0, 7'd0));
      // clamped to the last cell
      send(make_req(CMD_SET, 8'hFF, 8'hFF, 5'd31, 7'd127));
      // store in the last cell: wraps and scrolls
      send(make_req(CMD_PUT, 8'h5A, 8'h3C, 5'd0, 7'd0));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd23, 7'd79));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd31, 7'd127));
      // line feed on the bottom row scrolls too
      send(make_req(CMD_PUT, LF_CHAR, 8'h00, 5'd0, 7'd0));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd22, 7'd79));
      send(make_req(CMD_SET, 8'h00, 8'h00, 5'd3, 7'd79));
      send(make_req(CMD_PUT, 8'h7E, 8'h01, 5'd0, 7'd0));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd3, 7'd79));
      send(make_req(CMD_SET, 8'h00, 8'h00, 5'd24, 7'd127));
      send(make_req(CMD_PUT, CR_CHAR, 8'hFF, 5'd31, 7'd127));
      send(make_req(CMD_SET, 8'h00, 8'h00, 5'd31, 7'd0));
      send(make_req(CMD_CLEAR, 8'hAA, 8'h55, 5'd9, 7'd9));
      send(make_req(CMD_READ, 8'h00, 8'h00, 5'd0, 7'd0));
      send(make_req(CMD_READ, 8'hFF, 8'hFF, 5'd24, 7'd79));

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         if (phase == 0) begin
            write_attrs(8'h00, 8'hFF);
         end else begin
            write_attrs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
         target = items_sent + 135;
         while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               send_line();
            end else if (kind < 60) begin
               send(random_req(CMD_SET));
            end else if (kind < 75) begin
               it = random_req(CMD_READ);
               // mostly where the text lines land
               if ($urandom_range(0, 1) == 0) begin
                  it.row = 5'($urandom_range(0, 8));
                  it.col = 7'($urandom_range(0, 30));
               end
               send(it);
            end else if (kind < 85) begin
               it = random_req(CMD_SET);
               it.row = 5'($urandom_range(22, 31));
               send(it);
               repeat ($urandom_range(1, 3)) begin
                  send(make_req(CMD_PUT, LF_CHAR, 8'($urandom_range(0, 255)),
                                5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
               end
            end else if (kind < 88) begin
               send(random_req(CMD_CLEAR));
            end else begin
               send(random_req(cmd_type'($urandom_range(0, 3))));
            end
         end
      end

      drain();
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
